// ===== rtl/rmed_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median package
// Shared widths, register map, default parameter values and reset values
// of the multichannel running median core.
// ----------------------------------------------------------------------------
package rmed_pkg;

	// Fixed payload widths of the stream channels.
	localparam int CH_FIELD_W = 2;
	localparam int SAMPLE_W   = 16;
	localparam int CNT_W      = 7;

	// Register file: one window length register per channel, 32-bit words.
	localparam int NUM_REGS    = 4;
	localparam int REG_W       = 32;
	localparam int ADDR_W      = 4;
	localparam int IDX_W       = ADDR_W - 2;
	localparam int REG_WIN_CH0 = 0;

	// Defaults for the top level parameters.
	localparam int DEF_CHANNELS    = 4;
	localparam int DEF_MAX_WINDOW  = 64;
	localparam int DEF_SAMPLE_BITS = 16;

	localparam logic [CNT_W-1:0] WIN_RESET_LONG  = 7'd49;
	localparam logic [CNT_W-1:0] WIN_RESET_SHORT = 7'd1;

	// Reset window length of a channel. Channels zero and one use 49, the others 1.
	function automatic logic [CNT_W-1:0] win_reset_of(input int c);
		logic [CNT_W-1:0] r;
		priority if (c == REG_WIN_CH0 || c == REG_WIN_CH0 + 1) begin
			r = WIN_RESET_LONG;
		end else begin
			r = WIN_RESET_SHORT;
		end
		return r;
	endfunction

endpackage

// ===== rtl/rmed_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median stream interfaces
// Valid/ready channels for incoming samples and outgoing median results.
// ----------------------------------------------------------------------------
interface rmed_in_if
	import rmed_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CH_FIELD_W-1:0] channel;
	logic [SAMPLE_W-1:0]   sample;

	modport source (output valid, output channel, output sample, input ready);
	modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface rmed_out_if
	import rmed_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CH_FIELD_W-1:0] channel_out;
	logic [SAMPLE_W-1:0]   median;
	logic [CNT_W-1:0]      fill_count;

	modport source (output valid, output channel_out, output median, output fill_count,
		input ready);
	modport sink   (input valid, input channel_out, input median, input fill_count,
		output ready);
endinterface

// ===== rtl/multichannel_running_median_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel running median core
// Per-channel sliding window median of converter samples.
// ----------------------------------------------------------------------------
// Each accepted sample is stored in its channel's circular history and one
// result follows: the element of rank fill_count/2 among the filled entries
// (the upper median for an even count). The rank search reads the history
// memory through its single read port one entry per cycle and makes one
// pass over the window for each bit of the median, most significant bit
// first. A finished result waits in the output register while the next
// sample is taken. Samples tagged with a channel at or above CHANNELS are
// accepted and dropped. The history needs no clearing pass after reset:
// only entries written since the last reset or window register write are
// ever read. Writing a window register restarts that channel's history;
// registers are to be written only while the core is idle, which the core
// itself does not enforce.
// ----------------------------------------------------------------------------
module multichannel_running_median_core
	import rmed_pkg::*;
#(
	parameter int CHANNELS    = DEF_CHANNELS,
	parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]  pwdata,
	output logic [REG_W-1:0]  prdata,
	output logic              pready,
	rmed_in_if.sink           samples,
	rmed_out_if.source        medians
);

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int POS_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int AW    = CH_W + POS_W;

	logic [CNT_W-1:0]       win [CHANNELS];
	logic [CHANNELS-1:0]    clr;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [SAMPLE_BITS-1:0] mem_wdata;
	logic                   mem_re;
	logic [AW-1:0]          mem_raddr;
	logic [SAMPLE_BITS-1:0] mem_rdata;

	assign pready = 1'b1;

	rmed_cfg #(
		.CHANNELS (CHANNELS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.win     (win),
		.clr     (clr)
	);

	rmed_hist #(
		.ADDR_BITS (AW),
		.DATA_BITS (SAMPLE_BITS)
	) u_hist (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rmed_ctrl #(
		.CHANNELS    (CHANNELS),
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.win       (win),
		.clr       (clr),
		.samples   (samples),
		.medians   (medians),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

// ===== rtl/rmed_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median register file
// APB window length registers; a write also restarts that channel's history.
// ----------------------------------------------------------------------------
module rmed_cfg
	import rmed_pkg::*;
#(
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]  pwdata,
	output logic [REG_W-1:0]  prdata,
	output logic [CNT_W-1:0]  win [CHANNELS],
	output logic [CHANNELS-1:0] clr
);

	logic             wr;
	logic [IDX_W-1:0] idx;
	logic [CNT_W-1:0] win_q [CHANNELS];

	assign wr  = psel & penable & pwrite;
	assign idx = paddr[ADDR_W-1:2];

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			clr[c] = wr && (REG_WIN_CH0 + c == int'(idx));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				win_q[c] <= win_reset_of(c);
			end
		end else begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (clr[c]) begin
					win_q[c] <= pwdata[CNT_W-1:0];
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (REG_WIN_CH0 + c == int'(idx)) begin
				prdata = REG_W'(win_q[c]);
			end
		end
	end

	assign win = win_q;

endmodule

// ===== rtl/rmed_hist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median history memory
// Sample history of all channels, one write and one registered read port.
// ----------------------------------------------------------------------------
module rmed_hist
	import rmed_pkg::*;
#(
	parameter int ADDR_BITS = 8,
	parameter int DATA_BITS = DEF_SAMPLE_BITS
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [1 << ADDR_BITS];
	logic [DATA_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/rmed_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median controller
// Per-channel write position and fill count, and a bit-serial rank search
// that settles the median one bit per pass over the window.
// ----------------------------------------------------------------------------
module rmed_ctrl
	import rmed_pkg::*;
#(
	parameter int CHANNELS    = DEF_CHANNELS,
	parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
	localparam int POS_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
	localparam int AW    = CH_W + POS_W
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [CNT_W-1:0]       win [CHANNELS],
	input  logic [CHANNELS-1:0]    clr,
	rmed_in_if.sink                samples,
	rmed_out_if.source             medians,
	output logic                   mem_we,
	output logic [AW-1:0]          mem_waddr,
	output logic [SAMPLE_BITS-1:0] mem_wdata,
	output logic                   mem_re,
	output logic [AW-1:0]          mem_raddr,
	input  logic [SAMPLE_BITS-1:0] mem_rdata
);

	localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	function automatic logic [CNT_W-1:0] eff_len(input logic [CNT_W-1:0] w);
		logic [CNT_W-1:0] r;
		priority if (w == '0) begin
			r = CNT_W'(1);
		end else if (int'(w) > MAX_WINDOW) begin
			r = CNT_W'(MAX_WINDOW);
		end else begin
			r = w;
		end
		return r;
	endfunction

	logic [1:0]             state_q;
	logic [POS_W-1:0]       pos_q  [CHANNELS];
	logic [CNT_W-1:0]       fill_q [CHANNELS];

	logic                   acc;
	logic                   ch_ok;
	logic [CH_W-1:0]        ch;
	logic [CNT_W-1:0]       len;
	logic [POS_W-1:0]       pos_cur;
	logic [CMP_W-1:0]       pos_inc;
	logic [POS_W-1:0]       pos_nxt;
	logic [CNT_W-1:0]       fill_cur;
	logic [CNT_W-1:0]       fill_nxt;

	// Search state
	logic [CH_FIELD_W-1:0]  chan_q;
	logic [CH_W-1:0]        chb_q;
	logic [CNT_W-1:0]       n_q;
	logic [CNT_W-1:0]       rank_q;
	logic [CNT_W-1:0]       zeros_q;
	logic [SAMPLE_BITS-1:0] prefix_q;
	logic [SAMPLE_BITS-1:0] mask_q;
	logic [SAMPLE_BITS-1:0] bsel_q;
	logic [POS_W-1:0]       j_q;
	logic                   last_issue;
	logic                   v_s1;
	logic                   last_s1;
	logic                   hit;
	logic [CNT_W-1:0]       zeros_inc;
	logic                   decide;

	// Output register
	logic                   out_valid_q;
	logic [CH_FIELD_W-1:0]  out_chan_q;
	logic [SAMPLE_W-1:0]    out_med_q;
	logic [CNT_W-1:0]       out_fill_q;
	logic                   load;

	assign samples.ready = (state_q == ST_IDLE);
	assign acc           = samples.valid && samples.ready;
	assign ch_ok         = int'(samples.channel) < CHANNELS;
	assign ch            = CH_W'(samples.channel);

	always_comb begin
		len      = eff_len(win[ch]);
		pos_cur  = pos_q[ch];
		if (CMP_W'(pos_cur) >= CMP_W'(len)) begin
			pos_cur = '0;
		end
		pos_inc  = CMP_W'(pos_cur) + CMP_W'(1);
		pos_nxt  = (pos_inc >= CMP_W'(len)) ? '0 : POS_W'(pos_inc);
		fill_cur = fill_q[ch];
		fill_nxt = (fill_cur < len) ? fill_cur + CNT_W'(1) : len;
	end

	assign mem_we    = acc && ch_ok;
	assign mem_waddr = {ch, pos_cur};
	assign mem_wdata = SAMPLE_BITS'(samples.sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				pos_q[c]  <= '0;
				fill_q[c] <= '0;
			end
		end else begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (clr[c]) begin
					pos_q[c]  <= '0;
					fill_q[c] <= '0;
				end else if (mem_we && ch == CH_W'(c)) begin
					pos_q[c]  <= pos_nxt;
					fill_q[c] <= fill_nxt;
				end
			end
		end
	end

	// Reads run back to back over entries 0 to n-1, once per result bit.
	// Data returns from the registered read port in the following cycle and is counted against the current prefix.
	assign last_issue = (CMP_W'(j_q) + CMP_W'(1) == CMP_W'(n_q));
	assign mem_re     = (state_q == ST_SCAN);
	assign mem_raddr  = {chb_q, j_q};

	assign hit       = (((mem_rdata ^ prefix_q) & mask_q) == '0) &&
		((mem_rdata & bsel_q) == '0);
	assign zeros_inc = zeros_q + CNT_W'(hit);
	assign decide    = (state_q == ST_SCAN) && v_s1 && last_s1;
	assign load      = (state_q == ST_DONE) && (!out_valid_q || medians.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					if (acc && ch_ok) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (decide && bsel_q[0]) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && ch_ok) begin
			chan_q   <= samples.channel;
			chb_q    <= ch;
			n_q      <= fill_nxt;
			rank_q   <= fill_nxt >> 1;
			zeros_q  <= '0;
			prefix_q <= '0;
			mask_q   <= '0;
			bsel_q   <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			j_q      <= '0;
		end else if (state_q == ST_SCAN) begin
			j_q     <= last_issue ? '0 : j_q + POS_W'(1);
			last_s1 <= last_issue;
			if (decide) begin
				// The bit is one when the rank lies above all entries with a zero there.
				if (rank_q >= zeros_inc) begin
					prefix_q <= prefix_q | bsel_q;
					rank_q   <= rank_q - zeros_inc;
				end
				mask_q  <= mask_q | bsel_q;
				bsel_q  <= bsel_q >> 1;
				zeros_q <= '0;
			end else if (v_s1) begin
				zeros_q <= zeros_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (medians.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_chan_q <= chan_q;
			out_med_q  <= SAMPLE_W'(prefix_q);
			out_fill_q <= n_q;
		end
	end

	assign medians.valid       = out_valid_q;
	assign medians.channel_out = out_chan_q;
	assign medians.median      = out_med_q;
	assign medians.fill_count  = out_fill_q;

	a_bsel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> $onehot(bsel_q))
		else $error("bit select is not one-hot during the search");

	a_rank_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> rank_q < n_q)
		else $error("remaining rank left the candidate set");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> n_q != '0 && int'(n_q) <= MAX_WINDOW)
		else $error("fill count out of range during the search");

	a_last_bit_done: assert property (@(posedge clk) disable iff (!arst_n)
		decide && bsel_q[0] |=> state_q == ST_DONE)
		else $error("search did not finish after the last bit");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel running median core testbench
// Streams samples into the core under a series of window settings, with
// random idling on both stream sides and one long output stall. A scoreboard
// class tracks each channel's history and predicts every median, which is
// checked field by field against the results in order.
// ----------------------------------------------------------------------------
module tb_top;
	import rmed_pkg::*;

	typedef struct packed {
		logic [CH_FIELD_W-1:0] channel_out;
		logic [SAMPLE_W-1:0]   median;
		logic [CNT_W-1:0]      fill_count;
	} median_t;

	// Cycles without any transaction before the run is declared hung. The
	// limit covers the slowest sample plus the long output hold.
	localparam int STALL_LIMIT  = 8000;
	localparam int DRAIN_CYCLES = 1100;
	localparam int HOLD_CYCLES  = 400;

	class median_tracker;
		logic [CNT_W-1:0]    win_reg [DEF_CHANNELS];
		logic [SAMPLE_W-1:0] hist [DEF_CHANNELS][DEF_MAX_WINDOW];
		int unsigned         wr_pos [DEF_CHANNELS];
		int unsigned         fill [DEF_CHANNELS];
		median_t             pending_medians[$];
		int                  errors;

		function new();
			errors = 0;
			for (int c = 0; c < DEF_CHANNELS; c++) begin
				win_reg[c] = (c < 2) ? WIN_RESET_LONG : WIN_RESET_SHORT;
				wr_pos[c] = 0;
				fill[c] = 0;
			end
		endfunction

		function void set_window(int idx, logic [REG_W-1:0] value);
			win_reg[idx] = value[CNT_W-1:0];
			wr_pos[idx] = 0;
			fill[idx] = 0;
		endfunction

		function void take_sample(logic [CH_FIELD_W-1:0] ch, logic [SAMPLE_W-1:0] s);
			int unsigned len, pos, rank, below, upto;
			bit found;
			median_t m;
			len = win_reg[ch];
			if (len == 0)
				len = 1;
			else if (len > DEF_MAX_WINDOW)
				len = DEF_MAX_WINDOW;
			pos = wr_pos[ch];
			if (pos >= len)
				pos = 0;
			hist[ch][pos] = s;
			pos++;
			if (pos >= len)
				pos = 0;
			wr_pos[ch] = pos;
			if (fill[ch] < len)
				fill[ch]++;
			else
				fill[ch] = len;
			// The entry whose tie range covers the rank is the median.
			rank = fill[ch] / 2;
			found = 0;
			m.median = '0;
			for (int i = 0; i < fill[ch] && !found; i++) begin
				below = 0;
				upto = 0;
				for (int j = 0; j < fill[ch]; j++) begin
					if (hist[ch][j] < hist[ch][i])
						below++;
					if (hist[ch][j] <= hist[ch][i])
						upto++;
				end
				if (below <= rank && rank < upto) begin
					m.median = hist[ch][i];
					found = 1;
				end
			end
			m.channel_out = ch;
			m.fill_count = fill[ch][CNT_W-1:0];
			pending_medians.push_back(m);
		endfunction

		function void check_median(median_t got);
			median_t exp_m;
			if (pending_medians.size() == 0) begin
				$error("median result with nothing expected: channel %0d median %0d",
					got.channel_out, got.median);
				errors++;
				return;
			end
			exp_m = pending_medians.pop_front();
			if (got.channel_out !== exp_m.channel_out) begin
				$error("channel_out: expected %0d, got %0d", exp_m.channel_out,
					got.channel_out);
				errors++;
			end
			if (got.median !== exp_m.median) begin
				$error("median: expected %0d, got %0d", exp_m.median, got.median);
				errors++;
			end
			if (got.fill_count !== exp_m.fill_count) begin
				$error("fill_count: expected %0d, got %0d", exp_m.fill_count,
					got.fill_count);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [REG_W-1:0]  pwdata;
	logic [REG_W-1:0]  prdata;
	logic              pready;

	rmed_in_if  samples_if ();
	rmed_out_if medians_if ();

	median_tracker tracker;
	int            send_idle_pct;
	int            recv_idle_pct;
	int            hold_request;
	int            rnd_sent;
	int            idle_cycles;

	multichannel_running_median_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.samples (samples_if.sink),
		.medians (medians_if.source)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Called just after a falling edge; returns just after the falling edge that
	// follows acceptance, with valid still high, so back-to-back samples need no gap.
	task automatic send_sample(input logic [CH_FIELD_W-1:0] ch, input logic [SAMPLE_W-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			samples_if.valid = 1'b0;
			samples_if.channel = CH_FIELD_W'($urandom);
			samples_if.sample = SAMPLE_W'($urandom);
			@(negedge clk);
		end
		samples_if.valid = 1'b1;
		samples_if.channel = ch;
		samples_if.sample = s;
		do
			@(posedge clk);
		while (!samples_if.ready);
		tracker.take_sample(ch, s);
		@(negedge clk);
	endtask

	task automatic write_window(input int idx, input logic [REG_W-1:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ADDR_W'(idx * 4);
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		tracker.set_window(idx, value);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic wait_drained();
		samples_if.valid = 1'b0;
		while (tracker.pending_medians.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic apply_windows(input logic [REG_W-1:0] w0, input logic [REG_W-1:0] w1,
		input logic [REG_W-1:0] w2, input logic [REG_W-1:0] w3);
		wait_drained();
		write_window(REG_WIN_CH0, w0);
		write_window(REG_WIN_CH0 + 1, w1);
		write_window(REG_WIN_CH0 + 2, w2);
		write_window(REG_WIN_CH0 + 3, w3);
	endtask

	// Mix of spread-out values, clusters that force ties, and the extremes.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		logic [SAMPLE_W-1:0] v;
		case ($urandom_range(9))
			5, 6: v = SAMPLE_W'(32766 + $urandom_range(3));
			7: v = $urandom_range(1) ? '1 : '0;
			8: v = SAMPLE_W'($urandom_range(3) * 16'h1111);
			9: v = SAMPLE_W'(32748 + $urandom_range(40));
			default: v = SAMPLE_W'($urandom);
		endcase
		return v;
	endfunction

	task automatic run_random(input int n, input int bias_ch, input int bias_pct);
		logic [CH_FIELD_W-1:0] ch;
		for (int i = 0; i < n; i++) begin
			if (rnd_sent < 190) begin
				send_idle_pct = 31;
				recv_idle_pct = 57;
			end else if (rnd_sent < 380) begin
				send_idle_pct = 57;
				recv_idle_pct = 31;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if ($urandom_range(99) < bias_pct)
				ch = CH_FIELD_W'(bias_ch);
			else
				ch = CH_FIELD_W'($urandom_range(DEF_CHANNELS - 1));
			send_sample(ch, pick_sample());
			rnd_sent++;
		end
	endtask

	// Result side: sample at the rising edge, decide ready at the falling edge.
	initial begin
		int hold_left;
		bit hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		medians_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && medians_if.valid && medians_if.ready)
				tracker.check_median('{medians_if.channel_out, medians_if.median,
					medians_if.fill_count});
			@(negedge clk);
			if (hold_request > 0 && !hold_taken) begin
				hold_left = hold_request;
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				medians_if.ready = 1'b0;
				hold_left--;
			end else begin
				medians_if.ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((samples_if.valid && samples_if.ready) || (medians_if.valid && medians_if.ready)
			|| (psel && penable && pwrite)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("multichannel_running_median_core: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		tracker = new();
		hold_request = 0;
		rnd_sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		samples_if.valid = 1'b0;
		samples_if.channel = '0;
		samples_if.sample = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part with the reset window lengths: single-entry windows on
		// channels two and three, ties and even counts on channels zero and one.
		send_idle_pct = 31;
		recv_idle_pct = 57;
		send_sample(2, 16'h0000);
		send_sample(2, 16'hFFFF);
		send_sample(3, 16'h8000);
		send_sample(3, 16'h7FFF);
		send_sample(0, 16'hFFFF);
		send_sample(0, 16'h0000);
		send_sample(0, 16'hFFFF);
		send_sample(0, 16'h0000);
		send_sample(0, 16'h8000);
		send_sample(0, 16'h8000);
		send_sample(1, 16'h0001);
		send_sample(1, 16'h0003);
		send_sample(1, 16'h0002);
		send_sample(1, 16'h0002);

		// Zero length acts as one; upper data bits are outside the register.
		apply_windows(32'hFFFF_FF80, 32'h5A5A_5A82, 32'd3, 32'd4);
		send_sample(0, 16'h1234);
		send_sample(0, 16'h0001);
		send_sample(1, 16'h0010);
		send_sample(1, 16'h0005);
		send_sample(1, 16'h0007);
		send_sample(2, 16'hAAAA);
		send_sample(2, 16'h5555);
		send_sample(2, 16'hFFFF);
		send_sample(2, 16'h0000);
		run_random(110, 0, 0);

		apply_windows(32'd5, 32'd8, 32'd1, 32'd64);
		run_random(120, 3, 20);

		// Length above the maximum saturates; fill channel zero well past it.
		apply_windows(32'd127, 32'd2, 32'd6, 32'd1);
		run_random(80, 0, 85);

		apply_windows(32'd7, 32'd65, 32'd1, 32'd3);
		run_random(120, 1, 15);

		// No idling from here on; the long output hold backs up the input.
		apply_windows(32'd2, 32'd1, 32'd4, 32'd9);
		hold_request = HOLD_CYCLES;
		run_random(120, 0, 0);

		samples_if.valid = 1'b0;
		while (tracker.pending_medians.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_medians.size() == 0) begin
			$display("multichannel_running_median_core: match");
		end else begin
			$display("multichannel_running_median_core: mismatch");
		end
		$finish;
	end

endmodule
